FILE: rtl/hcsr_pkg.sv
// Shared constants, types and the hash fold function of the shard router.
package hcsr_pkg;

  localparam int unsigned DefMaxBuckets = 1024;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned HashW         = 64;
  localparam int unsigned ShardW        = 10;
  localparam int unsigned CountW        = 11;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned DivSteps      = 64;

  localparam logic [HashW-1:0] Golden  = 64'h0000_0000_9e37_79b9;
  localparam logic [HashW-1:0] AllOnes = '1;
  localparam int unsigned FoldShl = 6;
  localparam int unsigned FoldShr = 2;

  localparam int unsigned InDataW  = 208;
  localparam int unsigned InUserW  = CmdW;
  localparam int unsigned OutDataW = 208;

  localparam int unsigned InKeyALsb  = 0;
  localparam int unsigned InKeyBLsb  = 64;
  localparam int unsigned InKeyCLsb  = 128;
  localparam int unsigned InQueryLsb = 192;

  localparam int unsigned OutShardLsb  = 0;
  localparam int unsigned OutHashLsb   = 10;
  localparam int unsigned OutLowerLsb  = 74;
  localparam int unsigned OutUpperLsb  = 138;
  localparam int unsigned OutStatusBit = 202;
  localparam int unsigned OutPadW      = OutDataW - OutStatusBit - 1;

  typedef enum logic [CmdW-1:0] {
    CmdRoute2 = 2'd0,
    CmdRoute3 = 2'd1,
    CmdQuery  = 2'd2,
    CmdRsvd   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [HashW-1:0]  hash;
    logic [ShardW-1:0] query;
  } hcsr_item_t;

  function automatic logic [HashW-1:0] hc_fold(input logic [HashW-1:0] seed,
                                               input logic [KeyW-1:0]  k);
    return seed ^ (k + Golden + (seed << FoldShl) + (seed >> FoldShr));
  endfunction

endpackage

FILE: rtl/hcsr_cfg.sv
// Shard count register and the iterative divider that derives the hash stride.
module hcsr_cfg import hcsr_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = DefMaxBuckets,
  parameter int unsigned CW          = $clog2(MAX_BUCKETS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [CountW-1:0] wdata_i,
  output logic [CW-1:0]     n_o,
  output logic [HashW-1:0]  stride_o,
  output logic              busy_o
);

  localparam int unsigned EW   = (CW > CountW) ? CW : CountW;
  localparam int unsigned CntW = $clog2(DivSteps);
  localparam logic [CntW-1:0] LastStep = CntW'(DivSteps - 1);

  logic [CW-1:0]    n_q, eff;
  logic [HashW-1:0] stride_q, quo_q, quo_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [CW:0]      trial;
  logic             fits, pow2;
  logic [EW-1:0]    raw;

  always_comb begin
    raw = EW'(wdata_i);
    if (raw == '0) begin
      eff = CW'(1);
    end else if (raw > EW'(MAX_BUCKETS)) begin
      eff = CW'(MAX_BUCKETS);
    end else begin
      eff = CW'(raw);
    end
  end

  always_comb begin
    trial = {rem_q, 1'b1};
    fits  = trial >= {1'b0, n_q};
    rem_d = fits ? CW'(trial - {1'b0, n_q}) : CW'(trial);
    quo_d = {quo_q[HashW-2:0], fits};
    pow2  = (n_q != CW'(1)) && ((n_q & (n_q - CW'(1))) == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= CW'(1);
      stride_q <= AllOnes;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
    end else if (we_i) begin
      n_q    <= eff;
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == LastStep) begin
        busy_q   <= 1'b0;
        stride_q <= pow2 ? quo_d + HashW'(1) : quo_d;
      end
    end
  end

  assign n_o      = n_q;
  assign stride_o = stride_q;
  assign busy_o   = busy_q;

endmodule

FILE: rtl/hcsr_fold.sv
// Two-stage hash combine pipeline that folds the keys into one 64-bit hash.
module hcsr_fold import hcsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmd_e              cmd_i,
  input  logic [KeyW-1:0]   key_a_i,
  input  logic [KeyW-1:0]   key_b_i,
  input  logic [KeyW-1:0]   key_c_i,
  input  logic [ShardW-1:0] query_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hcsr_item_t        out_item_o
);

  logic              v1_q, v2_q, adv1, adv2;
  cmd_e              cmd1_q;
  logic [HashW-1:0]  seed1_q;
  logic [KeyW-1:0]   keyc1_q;
  logic [ShardW-1:0] query1_q;
  hcsr_item_t        item2_q, item2_d;

  assign adv2 = !v2_q || out_ready_i;
  assign adv1 = !v1_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_comb begin
    item2_d.cmd   = cmd1_q;
    item2_d.query = query1_q;
    item2_d.hash  = (cmd1_q == CmdRoute3) ? hc_fold(seed1_q, keyc1_q) : seed1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      cmd1_q   <= cmd_i;
      seed1_q  <= hc_fold(key_a_i + Golden, key_b_i);
      keyc1_q  <= key_c_i;
      query1_q <= query_i;
    end
    if (adv2) begin
      item2_q <= item2_d;
    end
  end

  assign in_ready_o  = adv1;
  assign out_valid_o = v2_q;
  assign out_item_o  = item2_q;

endmodule

FILE: rtl/hcsr_locate.sv
// Six-stage pipeline that finds the shard of a hash or the bounds of a shard.
module hcsr_locate import hcsr_pkg::*; #(
  parameter int unsigned CW = $clog2(DefMaxBuckets + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hcsr_item_t          in_item_i,
  input  logic [CW-1:0]       n_i,
  input  logic [HashW-1:0]    stride_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int unsigned Stages = 6;
  localparam int unsigned PW     = 32 + CW;
  localparam int unsigned SW     = PW + 1;
  localparam int unsigned QCW    = (CW > ShardW) ? CW : ShardW;

  logic [Stages-1:0] vld_q, adv;

  always_comb begin
    adv[Stages-1] = !vld_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  cmd_e             cmd_a_q, cmd_b_q, cmd_c_q, cmd_d_q, cmd_e_q;
  logic [HashW-1:0] hash_a_q, hash_b_q, hash_c_q, hash_d_q, hash_e_q;
  logic             bad_a_q, bad_b_q, bad_c_q, bad_d_q, bad_e_q;
  logic [CW-1:0]    q_a_q, est_b_q, est_c_q, est_d_q, est_e_q;
  logic [PW-1:0]    pl_a_q, ph_a_q, ml_c_q;
  logic [31:0]      mh_c_q;
  logic [HashW-1:0] prod_d_q, prod_e_q, rem_e_q, top_e_q;
  logic             last_e_q;
  logic [OutDataW-1:0] data_q, data_d;

  logic             route_b, route_f, query_f, bad_a;
  logic [SW-1:0]    sum_b;
  logic [CW:0]      cand_f;
  logic [CW-1:0]    nm1_f, shard_f;
  logic             inc_f;

  assign bad_a   = (in_item_i.cmd == CmdQuery) && (QCW'(in_item_i.query) >= QCW'(n_i));
  assign route_b = (cmd_a_q == CmdRoute2) || (cmd_a_q == CmdRoute3);
  assign sum_b   = SW'(ph_a_q) + SW'(pl_a_q >> 32);

  always_comb begin
    route_f = (cmd_e_q == CmdRoute2) || (cmd_e_q == CmdRoute3);
    query_f = (cmd_e_q == CmdQuery) && !bad_e_q;
    inc_f   = rem_e_q >= stride_i;
    cand_f  = (CW+1)'(est_e_q) + (CW+1)'(inc_f);
    nm1_f   = n_i - CW'(1);
    shard_f = (cand_f > {1'b0, nm1_f}) ? nm1_f : CW'(cand_f);
    data_d  = {OutPadW'(0),
               bad_e_q,
               query_f ? (last_e_q ? AllOnes : top_e_q) : '0,
               query_f ? prod_e_q : '0,
               route_f ? hash_e_q : '0,
               route_f ? ShardW'(shard_f) : ShardW'(0)};
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cmd_a_q  <= in_item_i.cmd;
      hash_a_q <= in_item_i.hash;
      bad_a_q  <= bad_a;
      q_a_q    <= CW'(in_item_i.query);
      pl_a_q   <= PW'(in_item_i.hash[31:0]) * PW'(n_i);
      ph_a_q   <= PW'(in_item_i.hash[63:32]) * PW'(n_i);
    end
    if (adv[1]) begin
      cmd_b_q  <= cmd_a_q;
      hash_b_q <= hash_a_q;
      bad_b_q  <= bad_a_q;
      est_b_q  <= route_b ? CW'(sum_b >> 32) : q_a_q;
    end
    if (adv[2]) begin
      cmd_c_q  <= cmd_b_q;
      hash_c_q <= hash_b_q;
      bad_c_q  <= bad_b_q;
      est_c_q  <= est_b_q;
      ml_c_q   <= PW'(stride_i[31:0]) * PW'(est_b_q);
      mh_c_q   <= 32'(PW'(stride_i[63:32]) * PW'(est_b_q));
    end
    if (adv[3]) begin
      cmd_d_q  <= cmd_c_q;
      hash_d_q <= hash_c_q;
      bad_d_q  <= bad_c_q;
      est_d_q  <= est_c_q;
      prod_d_q <= HashW'(ml_c_q) + {mh_c_q, 32'h0};
    end
    if (adv[4]) begin
      cmd_e_q  <= cmd_d_q;
      hash_e_q <= hash_d_q;
      bad_e_q  <= bad_d_q;
      est_e_q  <= est_d_q;
      prod_e_q <= prod_d_q;
      rem_e_q  <= hash_d_q - prod_d_q;
      top_e_q  <= prod_d_q + stride_i - HashW'(1);
      last_e_q <= ((CW+1)'(est_d_q) + (CW+1)'(1)) == (CW+1)'(n_i);
    end
    if (adv[5]) begin
      data_q <= data_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_data_o  = data_q;

endmodule

FILE: rtl/hash_combine_shard_router_top.sv
// Top level of the hash combine shard router.
//
// Input stream: one transfer carries a command in tuser and the keys and the
// queried shard in tdata. Route commands fold two or three keys into a 64-bit
// hash and return the shard that owns it; a boundary query returns the lowest
// and highest hash of a shard, with status set when the shard is not below
// the shard count. Every accepted transfer yields exactly one output transfer.
// The user must write the shard count through cfg_we_i and cfg_wdata_i only
// while no item is in flight; the block itself does not enforce this. A write
// starts a divider that derives the hash stride; the input side holds tready
// low while it runs. Two stages fold the keys, six locate the shard
// (estimate multiply and sum, bound multiply and sum, then remainder and
// correction compare). Throughput is one item per cycle while the receiver
// is ready and no divider runs. Reset sets the shard count to one with an
// all-ones stride and empties the pipeline. When the receiver stalls, the
// pipeline fills its bubbles and then holds; no transfer is lost or repeated.
module hash_combine_shard_router_top import hcsr_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = DefMaxBuckets
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // key_a, key_b, key_c, shard_query, zero padding
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // command
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // shard, hash_value, lower_bound, upper_bound, status, zero padding
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CW  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned QCW = (CW > ShardW) ? CW : ShardW;

  logic             cfg_busy, fold_ready, fold_valid, mid_valid, mid_ready;
  logic [CW-1:0]    cfg_n;
  logic [HashW-1:0] cfg_stride;
  hcsr_item_t       mid_item;

  hcsr_cfg #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .CW         (CW)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .wdata_i (cfg_wdata_i),
    .n_o     (cfg_n),
    .stride_o(cfg_stride),
    .busy_o  (cfg_busy)
  );

  assign fold_valid      = s_axis_tvalid_i && !cfg_busy;
  assign s_axis_tready_o = fold_ready && !cfg_busy;

  hcsr_fold u_fold (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fold_valid),
    .in_ready_o (fold_ready),
    .cmd_i      (cmd_e'(s_axis_tuser_i)),
    .key_a_i    (s_axis_tdata_i[InKeyALsb +: KeyW]),
    .key_b_i    (s_axis_tdata_i[InKeyBLsb +: KeyW]),
    .key_c_i    (s_axis_tdata_i[InKeyCLsb +: KeyW]),
    .query_i    (s_axis_tdata_i[InQueryLsb +: ShardW]),
    .out_valid_o(mid_valid),
    .out_ready_i(mid_ready),
    .out_item_o (mid_item)
  );

  hcsr_locate #(
    .CW(CW)
  ) u_locate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mid_valid),
    .in_ready_o (mid_ready),
    .in_item_i  (mid_item),
    .n_i        (cfg_n),
    .stride_i   (cfg_stride),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o)
  );

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_busy |-> !s_axis_tready_o)
    else $error("Input accepted while the stride divider is running.");

  a_write_starts_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> cfg_busy)
    else $error("Shard count write did not start the stride divider.");

  a_shard_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (QCW'(m_axis_tdata_o[OutShardLsb +: ShardW]) < QCW'(cfg_n)))
    else $error("Output shard is not below the shard count.");

  a_error_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OutStatusBit]
      |-> (m_axis_tdata_o[OutStatusBit-1:0] == '0))
    else $error("Failed query carries nonzero result fields.");

endmodule
